// ===== design/assert_macros.svh =====
// Assertion macros shared by the sorted key table modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SKT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/skt_pkg.sv =====
// Shared types for the sorted key table: operation and status codes and the
// command and status bundles passed between controller and datapath.
`timescale 1ns / 1ps

package skt_pkg;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_LIST   = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_ADDED     = 4'd0,
        ST_INVALID   = 4'd1,
        ST_DUPLICATE = 4'd2,
        ST_DELETED   = 4'd3,
        ST_NOT_FOUND = 4'd4,
        ST_FOUND     = 4'd5,
        ST_LISTED    = 4'd6,
        ST_EMPTY     = 4'd7,
        ST_FULL      = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        POS_ZERO = 2'd0,
        POS_SCAN = 2'd1,
        POS_LIST = 2'd2
    } pos_sel_t;

    typedef enum logic [1:0] {
        KSEL_ZERO  = 2'd0,
        KSEL_KEY   = 2'd1,
        KSEL_RDATA = 2'd2
    } key_sel_t;

    typedef struct packed {
        logic     start;
        logic     scan;
        logic     mv_add;
        logic     mv_del;
        logic     mv_step;
        logic     wr_key;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     list_rd;
        logic     list_next;
        logic     res_load;
        status_t  res_status;
        pos_sel_t res_pos;
        key_sel_t res_key;
        logic     res_last;
    } skt_cmd_t;

    typedef struct packed {
        func_t func;
        logic  key_zero;
        logic  cnt_zero;
        logic  cnt_full;
        logic  scan_done;
        logic  scan_match;
        logic  mv_done;
        logic  out_free;
        logic  list_last;
    } skt_sts_t;

endpackage

// ===== design/skt_dp.sv =====
// Datapath of the sorted key table: key memory, entry count, scan and move
// pointers and the output word register. Depends on skt_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module skt_dp #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 31,
    parameter int AW       = $clog2(DEPTH),
    parameter int CW       = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  skt_pkg::skt_cmd_t   cmd,
    output skt_pkg::skt_sts_t   sts,
    input  logic [1:0]          func,
    input  logic [KEY_BITS-1:0] key,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          status,
    output logic [AW-1:0]       position,
    output logic [KEY_BITS-1:0] key_out,
    output logic                last
);

    logic [KEY_BITS-1:0] mem [DEPTH];
    logic [KEY_BITS-1:0] rdata_reg;

    skt_pkg::func_t      func_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [AW-1:0]       cmp_ptr_reg, cmp_ptr_next;
    logic                rvalid_reg, rvalid_next;
    logic                done_reg, done_next;
    logic                match_reg, match_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       left_reg, left_next;
    logic                dir_up_reg, dir_up_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [AW-1:0]       pend_dst_reg, pend_dst_next;

    logic                out_valid_reg;
    skt_pkg::status_t    status_reg;
    logic [AW-1:0]       position_reg;
    logic [KEY_BITS-1:0] key_out_reg;
    logic                last_reg;

    logic                scan_issue, mv_issue, re, we;
    logic [AW-1:0]       waddr;
    logic [KEY_BITS-1:0] wdata;
    logic                out_free;

    assign out_free   = !out_valid_reg || out_ready;
    assign scan_issue = cmd.scan && !done_reg && (ptr_reg < count_reg);
    assign mv_issue   = cmd.mv_step && (left_reg != '0);
    assign re         = scan_issue || mv_issue || cmd.list_rd;

    // Write port: the pending word of a move, or the new key of an add.
    always_comb
    begin
        we    = 1'b0;
        waddr = pend_dst_reg;
        wdata = rdata_reg;
        if (cmd.mv_step && pend_valid_reg)
        begin
            we = 1'b1;
        end
        else if (cmd.wr_key)
        begin
            we    = 1'b1;
            waddr = pos_reg;
            wdata = key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg <= skt_pkg::func_t'(func);
            key_reg  <= key;
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        cmp_ptr_next    = cmp_ptr_reg;
        rvalid_next     = rvalid_reg;
        done_next       = done_reg;
        match_next      = match_reg;
        pos_next        = pos_reg;
        left_next       = left_reg;
        dir_up_next     = dir_up_reg;
        pend_valid_next = pend_valid_reg;
        pend_dst_next   = pend_dst_reg;

        if (cmd.start)
        begin
            ptr_next    = '0;
            rvalid_next = 1'b0;
            done_next   = 1'b0;
            match_next  = 1'b0;
        end

        // The scan stops at the first stored key not below the search key.
        // The table is sorted, so that is the match or the insertion point.
        if (cmd.scan && !done_reg)
        begin
            rvalid_next = scan_issue;
            if (scan_issue)
            begin
                ptr_next     = ptr_reg + 1'b1;
                cmp_ptr_next = ptr_reg[AW-1:0];
            end
            if (rvalid_reg && (rdata_reg >= key_reg))
            begin
                done_next   = 1'b1;
                match_next  = (rdata_reg == key_reg);
                pos_next    = cmp_ptr_reg;
                rvalid_next = 1'b0;
            end
            else if (!rvalid_reg && !scan_issue)
            begin
                done_next  = 1'b1;
                match_next = 1'b0;
                pos_next   = count_reg[AW-1:0];
            end
        end

        if (cmd.mv_add)
        begin
            left_next       = count_reg - CW'(pos_reg);
            ptr_next        = count_reg - 1'b1;
            dir_up_next     = 1'b1;
            pend_valid_next = 1'b0;
        end
        if (cmd.mv_del)
        begin
            left_next       = count_reg - CW'(pos_reg) - 1'b1;
            ptr_next        = CW'(pos_reg) + 1'b1;
            dir_up_next     = 1'b0;
            pend_valid_next = 1'b0;
        end
        if (cmd.mv_step)
        begin
            pend_valid_next = mv_issue;
            if (mv_issue)
            begin
                left_next     = left_reg - 1'b1;
                ptr_next      = dir_up_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
                pend_dst_next = dir_up_reg ? ptr_reg[AW-1:0] + 1'b1
                                           : ptr_reg[AW-1:0] - 1'b1;
            end
        end

        if (cmd.list_next)
        begin
            ptr_next = ptr_reg + 1'b1;
        end
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.cnt_dec)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ptr_reg        <= '0;
            rvalid_reg     <= 1'b0;
            done_reg       <= 1'b0;
            match_reg      <= 1'b0;
            left_reg       <= '0;
            dir_up_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            rvalid_reg     <= rvalid_next;
            done_reg       <= done_next;
            match_reg      <= match_next;
            left_reg       <= left_next;
            dir_up_reg     <= dir_up_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_ptr_reg  <= cmp_ptr_next;
        pos_reg      <= pos_next;
        pend_dst_reg <= pend_dst_next;
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            last_reg   <= cmd.res_last;
            case (cmd.res_pos)
                skt_pkg::POS_SCAN: position_reg <= pos_reg;
                skt_pkg::POS_LIST: position_reg <= ptr_reg[AW-1:0];
                default:           position_reg <= '0;
            endcase
            case (cmd.res_key)
                skt_pkg::KSEL_KEY:   key_out_reg <= key_reg;
                skt_pkg::KSEL_RDATA: key_out_reg <= rdata_reg;
                default:             key_out_reg <= '0;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign position  = position_reg;
    assign key_out   = key_out_reg;
    assign last      = last_reg;

    assign sts.func       = func_reg;
    assign sts.key_zero   = (key_reg == '0);
    assign sts.cnt_zero   = (count_reg == '0);
    assign sts.cnt_full   = (count_reg >= CW'(DEPTH));
    assign sts.scan_done  = done_reg;
    assign sts.scan_match = match_reg;
    assign sts.mv_done    = (left_reg == '0) && !pend_valid_reg;
    assign sts.out_free   = out_free;
    assign sts.list_last  = ((ptr_reg + 1'b1) == count_reg);

    `SKT_ASSERT_NOW(a_cnt_max, 1'b1, count_reg <= CW'(DEPTH),
        "entry count above table depth")
    `SKT_ASSERT_NOW(a_load_free, cmd.res_load, out_free,
        "output word overwritten before it was taken")
    `SKT_ASSERT_NEXT(a_cnt_hold, !cmd.cnt_inc && !cmd.cnt_dec,
        count_reg == $past(count_reg), "entry count changed without a command")

endmodule

// ===== design/skt_ctrl.sv =====
// Controller of the sorted key table: sequences scan, move, write and list
// steps and chooses each result code. Depends on skt_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module skt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  skt_pkg::skt_sts_t sts,
    output skt_pkg::skt_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_SCAN     = 8'b0000_0100,
        S_DECIDE   = 8'b0000_1000,
        S_MOVE     = 8'b0001_0000,
        S_FIN      = 8'b0010_0000,
        S_LIST_RD  = 8'b0100_0000,
        S_LIST_OUT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = skt_pkg::ST_ADDED;
        cmd.res_pos    = skt_pkg::POS_ZERO;
        cmd.res_key    = skt_pkg::KSEL_ZERO;
        cmd.res_last   = 1'b1;
        state_next     = state_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.func == skt_pkg::FUNC_ADD && sts.key_zero)
                begin
                    if (sts.out_free)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = skt_pkg::ST_INVALID;
                        state_next     = S_IDLE;
                    end
                end
                else if ((sts.func == skt_pkg::FUNC_DELETE ||
                          sts.func == skt_pkg::FUNC_LIST) && sts.cnt_zero)
                begin
                    if (sts.out_free)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = skt_pkg::ST_EMPTY;
                        state_next     = S_IDLE;
                    end
                end
                else if (sts.func == skt_pkg::FUNC_LIST)
                begin
                    state_next = S_LIST_RD;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (sts.func)
                    skt_pkg::FUNC_ADD:
                    begin
                        // A duplicate is reported ahead of a full table.
                        if (sts.scan_match || sts.cnt_full)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = sts.scan_match ? skt_pkg::ST_DUPLICATE
                                                                : skt_pkg::ST_FULL;
                                cmd.res_pos    = sts.scan_match ? skt_pkg::POS_SCAN
                                                                : skt_pkg::POS_ZERO;
                                state_next     = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.mv_add = 1'b1;
                            state_next = S_MOVE;
                        end
                    end
                    skt_pkg::FUNC_DELETE:
                    begin
                        if (sts.scan_match)
                        begin
                            cmd.mv_del = 1'b1;
                            state_next = S_MOVE;
                        end
                        else if (sts.out_free)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = skt_pkg::ST_NOT_FOUND;
                            state_next     = S_IDLE;
                        end
                    end
                    skt_pkg::FUNC_LOOKUP:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.res_load = 1'b1;
                            state_next   = S_IDLE;
                            if (sts.scan_match)
                            begin
                                cmd.res_status = skt_pkg::ST_FOUND;
                                cmd.res_pos    = skt_pkg::POS_SCAN;
                                cmd.res_key    = skt_pkg::KSEL_KEY;
                            end
                            else
                            begin
                                cmd.res_status = skt_pkg::ST_NOT_FOUND;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MOVE:
            begin
                if (sts.mv_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.mv_step = 1'b1;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_pos  = skt_pkg::POS_SCAN;
                    state_next   = S_IDLE;
                    if (sts.func == skt_pkg::FUNC_ADD)
                    begin
                        cmd.wr_key     = 1'b1;
                        cmd.cnt_inc    = 1'b1;
                        cmd.res_status = skt_pkg::ST_ADDED;
                    end
                    else
                    begin
                        cmd.cnt_dec    = 1'b1;
                        cmd.res_status = skt_pkg::ST_DELETED;
                    end
                end
            end
            S_LIST_RD:
            begin
                cmd.list_rd = 1'b1;
                state_next  = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = skt_pkg::ST_LISTED;
                    cmd.res_pos    = skt_pkg::POS_LIST;
                    cmd.res_key    = skt_pkg::KSEL_RDATA;
                    cmd.res_last   = sts.list_last;
                    cmd.list_next  = 1'b1;
                    state_next     = sts.list_last ? S_IDLE : S_LIST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SKT_ASSERT_NOW(a_wr_add, cmd.wr_key,
        sts.func == skt_pkg::FUNC_ADD && !sts.scan_match,
        "key written outside a successful add")
    `SKT_ASSERT_NOW(a_list_nonempty, state_reg == S_LIST_OUT, !sts.cnt_zero,
        "list stream running on an empty table")
    `SKT_ASSERT_NEXT(a_start_dispatch, cmd.start, state_reg == S_DISPATCH,
        "accepted word not dispatched")

endmodule

// ===== design/sorted_key_table_core.sv =====
// Top level of the sorted key table: ascending table of distinct keys with
// add, delete, lookup and list. Depends on skt_pkg, skt_ctrl and skt_dp.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   func, key
//   out      out_valid / out_ready status, position, key_out, last
//
// One word at a time: in_ready is high only while the controller idles. Add, delete and
// lookup dispatch, scan from the front and decide; an add or delete then shifts the later
// part of the table one key per cycle and finishes. List reads and outputs each key in turn.
// Reset clears the entry count and control state; the key memory needs no clearing.
// A stalled output holds the controller where it would load the next word.
`timescale 1ns / 1ps

module sorted_key_table_core #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 31
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 func,
    input  logic [KEY_BITS-1:0]        key,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [3:0]                 status,
    output logic [$clog2(DEPTH)-1:0]   position,
    output logic [KEY_BITS-1:0]        key_out,
    output logic                       last
);

    skt_pkg::skt_cmd_t cmd;
    skt_pkg::skt_sts_t sts;

    skt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    skt_dp #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .func      (func),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .position  (position),
        .key_out   (key_out),
        .last      (last)
    );

endmodule
